FILE: design/assert_macros.svh
// Assertion macros used by the extractor core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while reset is released.
`define LSTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define LSTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lste_pkg.sv
`timescale 1ns / 1ps

package lste_pkg;

  // One colour channel sample of the image stream.
  typedef struct packed {
    logic [7:0] channel_value;
    logic       first_of_image;
  } lste_in_t;

  // One recovered text byte.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } lste_out_t;

endpackage

FILE: design/lsb_stego_text_extract_core.sv
`timescale 1ns / 1ps
// Two-bit LSB steganography text extractor.
// The input channel takes one colour channel byte per beat (raster order, R G B per
// pixel) together with a first-of-image flag. Only the two lowest bits of each
// sample are used, bit 1 before bit 0. The first (LENGTH_BITS+1)/2 samples of an
// image form the text length in bytes; each following group of four samples
// forms one text byte, which leaves on the result channel with last_byte set on
// the final one. Samples after the text, and all samples of a zero-length image,
// produce nothing until first_of_image starts a new header.
// Throughput is one sample per cycle while in_ready is high: each sample is decoded
// in one pass of shift and count logic; the state registers update when it is taken.
// A byte appears on the result channel in the cycle after the beat that completes it.
// The result register holds one byte; while it is full and the receiver stalls,
// in_ready falls, and it rises again in the cycle the receiver takes the byte.
// Reset (synchronous, rst_n low) returns the decoder to header reading and
// empties the result register; no clearing pass is needed.
// A byte left half built when an image ends early is discarded at the next
// first_of_image.
module lsb_stego_text_extract_core
  import lste_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lste_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lste_out_t out_data
);

`include "assert_macros.svh"

  // Number of samples in the length header, rounded up for an odd width.
  localparam int HEADER_SAMPLES = (LENGTH_BITS + 1) / 2;
  localparam int HC_W           = $clog2(HEADER_SAMPLES);
  localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_SAMPLES - 1);
  localparam logic [1:0]      PAIR_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TEXT   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [HC_W-1:0]        header_count_r, header_count_nxt;
  logic [LENGTH_BITS-1:0] length_shift_r, length_shift_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]             pair_count_r, pair_count_nxt;
  logic [5:0]             byte_shift_r, byte_shift_nxt;

  logic      out_valid_r;
  lste_out_t out_r, out_nxt;

  // Working copies of the state, cleared when a new image begins.
  phase_t                 ph;
  logic [HC_W-1:0]        hc;
  logic [LENGTH_BITS-1:0] ls;
  logic [LENGTH_BITS-1:0] bl;
  logic [1:0]             pc;
  logic [5:0]             bs;
  logic [1:0]             bits;
  logic                   emit;
  logic                   in_fire;

  // A new sample may enter whenever the result register is empty or is being
  // emptied in this very cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    bits = in_data.channel_value[1:0];
    if (in_data.first_of_image) begin
      ph = PH_HEADER;
      hc = '0;
      ls = '0;
      bl = '0;
      pc = '0;
      bs = '0;
    end else begin
      ph = phase_r;
      hc = header_count_r;
      ls = length_shift_r;
      bl = bytes_left_r;
      pc = pair_count_r;
      bs = byte_shift_r;
    end

    phase_nxt        = ph;
    header_count_nxt = hc;
    length_shift_nxt = ls;
    bytes_left_nxt   = bl;
    pair_count_nxt   = pc;
    byte_shift_nxt   = bs;
    emit             = 1'b0;
    out_nxt          = out_r;

    case (ph)
      PH_HEADER: begin
        length_shift_nxt = {ls[LENGTH_BITS-3:0], bits};
        if (hc == HC_LAST) begin
          header_count_nxt = '0;
          bytes_left_nxt   = length_shift_nxt;
          pair_count_nxt   = '0;
          byte_shift_nxt   = '0;
          phase_nxt        = (length_shift_nxt == '0) ? PH_DONE : PH_TEXT;
        end else begin
          header_count_nxt = hc + HC_W'(1);
        end
      end
      PH_TEXT: begin
        if (pc == PAIR_LAST) begin
          emit              = 1'b1;
          pair_count_nxt    = '0;
          byte_shift_nxt    = '0;
          bytes_left_nxt    = bl - LENGTH_BITS'(1);
          out_nxt.text_byte = {bs, bits};
          out_nxt.last_byte = (bytes_left_nxt == '0);
          if (bytes_left_nxt == '0) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          byte_shift_nxt = {bs[3:0], bits};
          pair_count_nxt = pc + 2'd1;
        end
      end
      default: begin
        // Done, or the unused phase code: samples are ignored.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      length_shift_r <= '0;
      bytes_left_r   <= '0;
      pair_count_r   <= '0;
      byte_shift_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        header_count_r <= header_count_nxt;
        length_shift_r <= length_shift_nxt;
        bytes_left_r   <= bytes_left_nxt;
        pair_count_r   <= pair_count_nxt;
        byte_shift_r   <= byte_shift_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_r <= out_nxt;
    end
  end

  // A sample that completes no byte must leave the result register as it was,
  // apart from the receiver taking the pending byte.
  `LSTE_ASSERT(a_no_spurious_result,
    (in_fire && !emit) |=> (out_valid_r == ($past(out_valid_r) && !$past(out_ready))),
    "result appeared without a completed byte")

  // The final byte of the text always sends the decoder to done.
  `LSTE_ASSERT(a_last_ends_text,
    (in_fire && emit && out_nxt.last_byte) |=> (phase_r == PH_DONE),
    "decoder did not stop after the last byte")

  // While text is being read there is always at least one byte still owed.
  `LSTE_ASSERT(a_text_has_bytes,
    (phase_r == PH_TEXT) |-> (bytes_left_r != '0),
    "text phase with no bytes left")

  // Header reading never starts with a half built text byte.
  `LSTE_ASSERT(a_header_clean_pairs,
    (phase_r == PH_HEADER) |-> (pair_count_r == '0 && byte_shift_r == '0),
    "stale text bits during header")

endmodule

FILE: dv/lsb_stego_text_extract_core_tb.sv
`timescale 1ns / 1ps

module lsb_stego_text_extract_core_tb;
  import lste_pkg::*;

  localparam int LB          = 16;
  // The header takes the rounded-up number of two-bit pairs.
  localparam int HDR_SAMPLES = (LB + 1) / 2;

  // Decoder phases as the predictor tracks them. The spare code behaves as done.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TEXT   = 2'd1,
    PH_DONE   = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  lste_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lste_out_t out_data;

  lsb_stego_text_extract_core #(
    .LENGTH_BITS(LB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be offered, and text bytes the decoder owes us.
  lste_in_t  sample_queue[$];
  lste_out_t text_due[$];
  int        n_samples  = 0;
  int        mismatches = 0;

  // Set at each rising edge when the input beat in flight was taken.
  logic      in_took   = 1'b0;
  // While calm is set neither side idles, so long stretches at full rate occur.
  logic      calm      = 1'b0;
  int        calm_left = 100;
  int        in_gap    = 0;
  int        stall_left = 0;

  // Predictor state, kept at the block's own widths apart from the header count.
  phase_t        ph;
  int            hdr_cnt;
  logic [LB-1:0] len_acc;
  logic [LB-1:0] bytes_left;
  logic [1:0]    pair_cnt;
  logic [5:0]    byte_acc;

  task automatic clear_decoder();
    ph         = PH_HEADER;
    hdr_cnt    = 0;
    len_acc    = '0;
    bytes_left = '0;
    pair_cnt   = '0;
    byte_acc   = '0;
  endtask

  // Advances the predictor by one accepted sample and records any byte it yields.
  task automatic decode_sample(input lste_in_t s);
    logic [1:0] pair;
    lste_out_t  r;
    pair = s.channel_value[1:0];
    if (s.first_of_image) clear_decoder();
    case (ph)
      PH_HEADER: begin
        len_acc = {len_acc[LB-3:0], pair};
        hdr_cnt++;
        if (hdr_cnt >= HDR_SAMPLES) begin
          // A zero length goes straight to done and yields nothing.
          hdr_cnt    = 0;
          bytes_left = len_acc;
          pair_cnt   = '0;
          byte_acc   = '0;
          ph         = (len_acc == '0) ? PH_DONE : PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (pair_cnt == 2'd3) begin
          r.text_byte = {byte_acc, pair};
          bytes_left  = bytes_left - LB'(1);
          r.last_byte = (bytes_left == '0);
          text_due    = {text_due, r};
          pair_cnt = '0;
          byte_acc = '0;
          if (bytes_left == '0) ph = PH_DONE;
        end else begin
          byte_acc = {byte_acc[3:0], pair};
          pair_cnt = pair_cnt + 2'd1;
        end
      end
      default: begin
        // Done, or the spare code: samples are ignored until a new image starts.
      end
    endcase
  endtask

  // Idle lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_sample(input logic [7:0] v, input logic f);
    lste_in_t s;
    s.channel_value = v;
    s.first_of_image = f;
    sample_queue = {sample_queue, s};
    n_samples++;
  endtask

  // Queues one image carrying the given length. A non-negative cut ends the
  // image after that many samples, which may leave a byte half built. The tail
  // adds samples after the image, which the decoder ignores unless it was cut.
  task automatic queue_image(input logic [LB-1:0] len, input int cut, input int tail);
    int         total;
    int         n;
    logic [1:0] pair;
    logic [5:0] hi;
    total = HDR_SAMPLES + 4 * int'(len);
    n = (cut >= 0 && cut < total) ? cut : total;
    for (int i = 0; i < n; i++) begin
      hi = 6'($urandom_range(0, 63));
      if (i < HDR_SAMPLES) pair = len[2 * (HDR_SAMPLES - 1 - i) +: 2];
      else                 pair = 2'($urandom_range(0, 3));
      queue_sample({hi, pair}, i == 0);
    end
    for (int i = 0; i < tail; i++) queue_sample(8'($urandom_range(0, 255)), 1'b0);
  endtask

  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm      <= ~calm;
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Input driver. A beat stays on the bus, unchanged, until the edge that takes
  // it; only then does the gap before the next one start counting.
  always @(negedge clk) begin
    logic waiting;
    waiting = in_valid && !in_took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!waiting) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_data  <= sample_queue.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Stalls are independent of out_valid, so they land on every phase.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Monitor and predictor. A byte leaves only after the edge that takes the beat
  // completing it, so checking before predicting at the same edge is safe.
  always @(posedge clk) begin
    lste_out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      clear_decoder();
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat text_byte %02h last_byte %0d", $realtime,
                     out_data.text_byte, out_data.last_byte);
          mismatches++;
        end else begin
          want = text_due.pop_front();
          if (out_data.text_byte !== want.text_byte ||
              out_data.last_byte !== want.last_byte) begin
            if (mismatches < 10)
              $display("%0t: mismatch text_byte exp %02h got %02h, last_byte exp %0d got %0d",
                       $realtime, want.text_byte, out_data.text_byte,
                       want.last_byte, out_data.last_byte);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) decode_sample(in_data);
    end
  end

  initial begin
    int         r;
    logic [LB-1:0] len;
    int         cut;

    // Zero length: the header completes and nothing follows, even for the
    // sample after it.
    queue_sample(8'h00, 1'b1);
    for (int i = 1; i < HDR_SAMPLES; i++) queue_sample((i % 2) ? 8'hFC : 8'h00, 1'b0);
    queue_sample(8'hFF, 1'b0);
    // A one-byte text made from extreme sample values, then an ignored sample.
    queue_sample(8'hFC, 1'b1);
    for (int i = 1; i < HDR_SAMPLES - 1; i++) queue_sample((i % 2) ? 8'h00 : 8'hFC, 1'b0);
    queue_sample(8'hFD, 1'b0);
    queue_sample(8'hFF, 1'b0);
    queue_sample(8'h00, 1'b0);
    queue_sample(8'hFF, 1'b0);
    queue_sample(8'h00, 1'b0);
    queue_sample(8'h03, 1'b0);
    // A header broken off part way; a later flagged image restarts it.
    queue_sample(8'hFF, 1'b1);
    queue_sample(8'hFF, 1'b0);

    // Random images: most well formed with short texts, some cut short, a few
    // with huge lengths that are always cut, and some loose noise samples.
    while (n_samples < 500) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        queue_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        if (r < 12) begin
          case ($urandom_range(0, 2))
            0:       len = '1;
            1:       len = {1'b1, {(LB-1){1'b0}}};
            default: len = LB'($urandom_range(256, 65535));
          endcase
          cut = $urandom_range(1, HDR_SAMPLES + 4 * 8);
        end else begin
          len = LB'($urandom_range(0, (r < 22) ? 24 : 5));
          cut = ($urandom_range(0, 7) == 0) ?
                $urandom_range(1, HDR_SAMPLES + 4 * int'(len)) : -1;
        end
        queue_image(len, cut, $urandom_range(0, 3));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sample_queue.size() != 0 || in_valid) @(posedge clk);
    while (text_due.size() != 0) @(posedge clk);
    // Waiting on catches any stray beat after the last expected one.
    repeat (20) @(posedge clk);
    if (text_due.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("lsb_stego_text_extract_core_tb: PASS");
    end else begin
      $display("lsb_stego_text_extract_core_tb: FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run, long idles and stalls on every beat.
  initial begin
    #5_000_000;
    $display("lsb_stego_text_extract_core_tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/lste_pkg.sv
design/lsb_stego_text_extract_core.sv
dv/lsb_stego_text_extract_core_tb.sv
